// ===== src/gfq_pkg.sv =====
// Package: transaction types, codes and the narrow modulo helper for the grouped FIFO queue.
`timescale 1ns / 1ps

package gfq_pkg;

  localparam int MEMBER_W = 12;
  localparam int GROUP_W  = 8;
  localparam int OPCODE_W = 2;
  localparam int STATUS_W = 2;

  // Opcodes
  localparam logic [OPCODE_W-1:0] OP_MAP  = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_ENQ  = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_DEQ  = 2'd2;
  localparam logic [OPCODE_W-1:0] OP_RSVD = 2'd3;  // unused, answers ok with no effect

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [MEMBER_W-1:0] member_id;
    logic [GROUP_W-1:0]  group_id;
  } gfq_in_t;

  typedef struct packed {
    logic [MEMBER_W-1:0] out_member;
    logic [STATUS_W-1:0] status;
  } gfq_out_t;

  // Remainder of a narrow value by a constant modulus. The quotient stays
  // below 256 for every legal modulus, so eight conditional subtracts do it.
  function automatic logic [31:0] mod_reduce(input logic [31:0] value,
                                             input logic [31:0] modulus);
    logic [31:0] rem;
    logic [31:0] part;
    rem = value;
    for (int k = 7; k >= 0; k--) begin
      part = modulus << k;
      if (rem >= part) begin
        rem = rem - part;
      end
    end
    return rem;
  endfunction

endpackage

// ===== src/grouped_fifo_queue_core.sv =====
// Top level: grouped FIFO (team queue) with linked per-group lists over a shared slot pool.
//
//  channel  | handshake         | payload
//  ---------+-------------------+---------------------------------------
//  command  | start / busy      | in_i  (opcode, member_id, group_id)
//  result   | valid_o (strobe)  | out_o (out_member, status)
//
// A transaction is taken at a clock edge with start high and busy low.
// Map, opcode 3, dequeue on empty and enqueue on full pool: result in the next cycle.
// Enqueue steps through ENQ_A and ENQ_B; dequeue through DEQ_A, DEQ_B and DEQ_C.
// Each state is one read-then-write step through the synchronous RAMs.
// After reset a clearing pass zeroes the member map and group table; busy
// stays high meanwhile.
// The result is shown for one cycle; the receiver cannot stall it.
`timescale 1ns / 1ps

module grouped_fifo_queue_core
  import gfq_pkg::*;
#(
  parameter int NUM_GROUPS     = 256,
  parameter int NUM_MEMBER_IDS = 4096,
  parameter int NUM_SLOTS      = 1024
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  gfq_in_t  in_i,
  output logic     valid_o,
  output gfq_out_t out_o
);

  localparam int GW    = $clog2(NUM_GROUPS);
  localparam int MW    = $clog2(NUM_MEMBER_IDS);
  localparam int SW    = $clog2(NUM_SLOTS);
  localparam int CW    = $clog2(NUM_SLOTS + 1);
  localparam int OCW   = $clog2(NUM_GROUPS + 1);
  localparam int CLR_N = (NUM_MEMBER_IDS > NUM_GROUPS) ? NUM_MEMBER_IDS : NUM_GROUPS;
  localparam int CLRW  = $clog2(CLR_N);
  localparam int GRP_W = 2 * SW + CW;

  typedef struct packed {
    logic [SW-1:0] head;
    logic [SW-1:0] tail;
    logic [CW-1:0] wait_cnt;
  } grp_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ENQ_A,
    S_ENQ_B,
    S_DEQ_A,
    S_DEQ_B,
    S_DEQ_C
  } state_e;

  state_e state_q;

  // Control registers
  logic [CLRW-1:0] clr_q;
  logic [CW-1:0]   fc_q;
  logic [CW-1:0]   low_q;     // lowest free count reached; stack entries below it are untouched
  logic [GW-1:0]   front_q;
  logic [GW-1:0]   back_q;
  logic [OCW-1:0]  oc_q;
  logic            valid_q;

  // Payload registers
  gfq_out_t        out_q;
  logic [MEMBER_W-1:0] m_q;
  logic [GW-1:0]   g_q;
  logic [SW-1:0]   s_q;
  logic            pop_low_q;
  grp_t            ent_q;

  // RAM ports
  logic              gom_we;
  logic [MW-1:0]     gom_waddr;
  logic [GW-1:0]     gom_wdata;
  logic [GW-1:0]     gom_rdata;
  logic              grp_we;
  logic [GW-1:0]     grp_waddr;
  grp_t              grp_wdata;
  logic [GW-1:0]     grp_raddr;
  grp_t              grp_rdata;
  logic              ord_we;
  logic [GW-1:0]     ord_rdata;
  logic              fstk_we;
  logic [SW-1:0]     fstk_rdata;
  logic              sval_we;
  logic [MEMBER_W-1:0] sval_rdata;
  logic              slink_we;
  logic [SW-1:0]     slink_waddr;
  logic [SW-1:0]     slink_wdata;
  logic [SW-1:0]     slink_rdata;

  // Input reduction and derived values
  logic [MEMBER_W-1:0] m_red;
  logic [MW-1:0]       m_idx;
  logic [GW-1:0]       g_red;
  logic [CW-1:0]       pop_idx;
  logic [SW-1:0]       s_sel;
  logic                clear_gom;
  logic                clear_grp;
  logic                accept;
  logic [CW-1:0]       new_wait;
  logic [GW-1:0]       front_inc;
  logic [GW-1:0]       back_inc;

  assign m_red   = MEMBER_W'(mod_reduce(32'(in_i.member_id), 32'(NUM_MEMBER_IDS)));
  assign m_idx   = MW'(m_red);
  assign g_red   = GW'(mod_reduce(32'(in_i.group_id), 32'(NUM_GROUPS)));
  assign pop_idx = fc_q - 1'b1;
  assign s_sel   = pop_low_q ? pop_idx[SW-1:0] : fstk_rdata;
  assign accept  = (state_q == S_IDLE) && start;

  assign clear_gom = (state_q == S_CLEAR) && (32'(clr_q) < 32'(NUM_MEMBER_IDS));
  assign clear_grp = (state_q == S_CLEAR) && (32'(clr_q) < 32'(NUM_GROUPS));

  assign new_wait  = (ent_q.wait_cnt != '0) ? ent_q.wait_cnt - 1'b1 : '0;
  assign front_inc = (front_q == GW'(NUM_GROUPS - 1)) ? '0 : front_q + 1'b1;
  assign back_inc  = (back_q == GW'(NUM_GROUPS - 1)) ? '0 : back_q + 1'b1;

  // Member-to-group map: cleared after reset, written by map
  assign gom_we    = clear_gom || (accept && (in_i.opcode == OP_MAP));
  assign gom_waddr = (state_q == S_CLEAR) ? clr_q[MW-1:0] : m_idx;
  assign gom_wdata = (state_q == S_CLEAR) ? '0 : g_red;

  // Group table: head, tail and waiting count per group
  always_comb begin
    grp_we    = 1'b0;
    grp_waddr = g_q;
    grp_wdata = '0;
    grp_raddr = gom_rdata;
    case (state_q)
      S_CLEAR: begin
        grp_we    = clear_grp;
        grp_waddr = clr_q[GW-1:0];
      end
      S_ENQ_B: begin
        grp_we = 1'b1;
        if (grp_rdata.wait_cnt == '0) begin
          grp_wdata = '{head: s_q, tail: s_q, wait_cnt: CW'(1)};
        end else begin
          grp_wdata = '{head: grp_rdata.head, tail: s_q,
                        wait_cnt: grp_rdata.wait_cnt + 1'b1};
        end
      end
      S_DEQ_A: begin
        grp_raddr = ord_rdata;
      end
      S_DEQ_C: begin
        grp_we    = 1'b1;
        grp_wdata = '{head: (new_wait == '0) ? ent_q.head : slink_rdata,
                      tail: ent_q.tail, wait_cnt: new_wait};
      end
      default: begin
        grp_we = 1'b0;
      end
    endcase
  end

  // Group order ring
  assign ord_we = (state_q == S_ENQ_B) && (grp_rdata.wait_cnt == '0) &&
                  (oc_q < OCW'(NUM_GROUPS));

  // Free slot stack: pushes on dequeue
  assign fstk_we = (state_q == S_DEQ_C) && (fc_q < CW'(NUM_SLOTS));

  // Slot value and link stores
  assign sval_we     = (state_q == S_ENQ_A);
  assign slink_we    = (state_q == S_ENQ_A) ||
                       ((state_q == S_ENQ_B) && (grp_rdata.wait_cnt != '0));
  assign slink_waddr = (state_q == S_ENQ_A) ? s_sel : grp_rdata.tail;
  assign slink_wdata = (state_q == S_ENQ_A) ? '0 : s_q;

  gfq_ram #(.WIDTH(GW), .DEPTH(NUM_MEMBER_IDS)) u_gom (
    .clk_i   (clk_i),
    .we_i    (gom_we),
    .waddr_i (gom_waddr),
    .wdata_i (gom_wdata),
    .raddr_i (m_idx),
    .rdata_o (gom_rdata)
  );

  gfq_ram #(.WIDTH(GRP_W), .DEPTH(NUM_GROUPS)) u_grp (
    .clk_i   (clk_i),
    .we_i    (grp_we),
    .waddr_i (grp_waddr),
    .wdata_i (grp_wdata),
    .raddr_i (grp_raddr),
    .rdata_o (grp_rdata)
  );

  gfq_ram #(.WIDTH(GW), .DEPTH(NUM_GROUPS)) u_ord (
    .clk_i   (clk_i),
    .we_i    (ord_we),
    .waddr_i (back_q),
    .wdata_i (g_q),
    .raddr_i (front_q),
    .rdata_o (ord_rdata)
  );

  gfq_ram #(.WIDTH(SW), .DEPTH(NUM_SLOTS)) u_fstk (
    .clk_i   (clk_i),
    .we_i    (fstk_we),
    .waddr_i (fc_q[SW-1:0]),
    .wdata_i (ent_q.head),
    .raddr_i (pop_idx[SW-1:0]),
    .rdata_o (fstk_rdata)
  );

  gfq_ram #(.WIDTH(MEMBER_W), .DEPTH(NUM_SLOTS)) u_sval (
    .clk_i   (clk_i),
    .we_i    (sval_we),
    .waddr_i (s_sel),
    .wdata_i (m_q),
    .raddr_i (grp_rdata.head),
    .rdata_o (sval_rdata)
  );

  gfq_ram #(.WIDTH(SW), .DEPTH(NUM_SLOTS)) u_slink (
    .clk_i   (clk_i),
    .we_i    (slink_we),
    .waddr_i (slink_waddr),
    .wdata_i (slink_wdata),
    .raddr_i (grp_rdata.head),
    .rdata_o (slink_rdata)
  );

  // Sequencer with registered result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      clr_q     <= '0;
      fc_q      <= CW'(NUM_SLOTS);
      low_q     <= CW'(NUM_SLOTS);
      front_q   <= '0;
      back_q    <= '0;
      oc_q      <= '0;
      valid_q   <= 1'b0;
      out_q     <= '0;
      m_q       <= '0;
      g_q       <= '0;
      s_q       <= '0;
      pop_low_q <= 1'b0;
      ent_q     <= '0;
    end else begin
      case (state_q)
        S_CLEAR: begin
          valid_q <= 1'b0;
          clr_q   <= clr_q + 1'b1;
          if (32'(clr_q) == 32'(CLR_N - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            case (in_i.opcode)
              OP_ENQ: begin
                if (fc_q == '0) begin
                  valid_q <= 1'b1;
                  out_q   <= '{out_member: '0, status: ST_FULL};
                end else begin
                  valid_q   <= 1'b0;
                  m_q       <= m_red;
                  pop_low_q <= (pop_idx < low_q);
                  state_q   <= S_ENQ_A;
                end
              end
              OP_DEQ: begin
                if (oc_q == '0) begin
                  valid_q <= 1'b1;
                  out_q   <= '{out_member: '0, status: ST_EMPTY};
                end else begin
                  valid_q <= 1'b0;
                  state_q <= S_DEQ_A;
                end
              end
              default: begin
                // map (written through the RAM port) and the unused opcode
                valid_q <= 1'b1;
                out_q   <= '{out_member: '0, status: ST_OK};
              end
            endcase
          end else begin
            valid_q <= 1'b0;
          end
        end
        S_ENQ_A: begin
          valid_q <= 1'b0;
          g_q     <= gom_rdata;
          s_q     <= s_sel;
          state_q <= S_ENQ_B;
        end
        S_ENQ_B: begin
          if ((grp_rdata.wait_cnt == '0) && (oc_q < OCW'(NUM_GROUPS))) begin
            back_q <= back_inc;
            oc_q   <= oc_q + 1'b1;
          end
          fc_q <= pop_idx;
          if (pop_idx < low_q) begin
            low_q <= pop_idx;
          end
          valid_q <= 1'b1;
          out_q   <= '{out_member: '0, status: ST_OK};
          state_q <= S_IDLE;
        end
        S_DEQ_A: begin
          valid_q <= 1'b0;
          g_q     <= ord_rdata;
          state_q <= S_DEQ_B;
        end
        S_DEQ_B: begin
          valid_q <= 1'b0;
          ent_q   <= grp_rdata;
          state_q <= S_DEQ_C;
        end
        S_DEQ_C: begin
          if (fc_q < CW'(NUM_SLOTS)) begin
            fc_q <= fc_q + 1'b1;
          end
          if (new_wait == '0) begin
            front_q <= front_inc;
            oc_q    <= oc_q - 1'b1;
          end
          valid_q <= 1'b1;
          out_q   <= '{out_member: sval_rdata, status: ST_OK};
          state_q <= S_IDLE;
        end
        default: begin
          valid_q <= 1'b0;
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign busy    = (state_q != S_IDLE);
  assign valid_o = valid_q;
  assign out_o   = out_q;

endmodule

// ===== src/gfq_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module gfq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
